>>> design/fid_pkg.sv
// Shared widths, register indexes and reset values for the frame input debouncer.
`timescale 1ns / 1ps
package fid_pkg;

  localparam int unsigned EncoderBits = 16;
  localparam int unsigned PotBits     = 10;
  localparam int unsigned DeltaBits   = EncoderBits + 1;

  localparam int unsigned RunBits   = 8;
  localparam int unsigned ThreshW   = 8;
  localparam int unsigned ScaleW    = 11;
  localparam int unsigned SensW     = 18;

  // Pot activity compares |diff| * scale against sensitivity * 4.
  localparam int unsigned ProdW     = PotBits + ScaleW;
  localparam int unsigned SensXW    = SensW + 2;
  localparam int unsigned CmpW      = (ProdW > SensXW) ? ProdW : SensXW;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 18;

  localparam logic [CfgIdxW-1:0] CFG_HOLD_THRESHOLD  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POT_SCALE       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_POT_SENSITIVITY = 2'd2;

  localparam logic [ThreshW-1:0] HOLD_THRESHOLD_RST  = 8'd3;
  localparam logic [ScaleW-1:0]  POT_SCALE_RST       = 11'd1024;
  localparam logic [SensW-1:0]   POT_SENSITIVITY_RST = 18'd256;

  localparam logic [RunBits-1:0] RUN_MAX = {RunBits{1'b1}};

endpackage

>>> design/frame_input_debounce_events.sv
// Frame input debouncer: button hold detection, edge events, encoder delta, activity.
// Path: an accepted input beat passes the input register, then the result register.
// Throughput: one frame per cycle; the input register and the result register
// each move whenever the stage after them is free or drains in the same cycle.
// Reset: run counters, last-frame state and valid flags clear; registers take
// threshold 3, scale 1024 and sensitivity 256.
`timescale 1ns / 1ps
module frame_input_debounce_events (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_we_i,
  input  logic [fid_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fid_pkg::CfgDataW-1:0]    cfg_data_i,

  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [fid_pkg::EncoderBits-1:0] encoder_position_i,
  input  logic                            encoder_switch_i,
  input  logic                            left_level_i,
  input  logic                            middle_level_i,
  input  logic                            right_level_i,
  input  logic [fid_pkg::PotBits-1:0]     pot_sample_i,

  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            right_held_o,
  output logic                            middle_held_o,
  output logic                            left_held_o,
  output logic                            reset_combo_o,
  output logic signed [fid_pkg::DeltaBits-1:0] pos_delta_o,
  output logic                            activity_o,
  output logic                            right_event_o,
  output logic                            middle_event_o,
  output logic                            left_event_o,
  output logic                            switch_event_o,
  output logic                            reset_event_o,
  output logic                            pot_changed_o
);

  // Configuration registers.
  logic [fid_pkg::ThreshW-1:0] threshold_q;
  logic [fid_pkg::ScaleW-1:0]  scale_q;
  logic [fid_pkg::SensW-1:0]   sens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= fid_pkg::HOLD_THRESHOLD_RST;
      scale_q     <= fid_pkg::POT_SCALE_RST;
      sens_q      <= fid_pkg::POT_SENSITIVITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fid_pkg::CFG_HOLD_THRESHOLD:  threshold_q <= cfg_data_i[fid_pkg::ThreshW-1:0];
        fid_pkg::CFG_POT_SCALE:       scale_q     <= cfg_data_i[fid_pkg::ScaleW-1:0];
        fid_pkg::CFG_POT_SENSITIVITY: sens_q      <= cfg_data_i[fid_pkg::SensW-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic                                   in_vld_q;
  logic signed [fid_pkg::EncoderBits-1:0] pos_q;
  logic                                   sw_q;
  logic                                   left_q;
  logic                                   middle_q;
  logic                                   right_q;
  logic [fid_pkg::PotBits-1:0]            pot_q;

  logic advance;

  assign advance    = in_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pos_q    <= encoder_position_i;
      sw_q     <= encoder_switch_i;
      left_q   <= left_level_i;
      middle_q <= middle_level_i;
      right_q  <= right_level_i;
      pot_q    <= pot_sample_i;
    end
  end

  // Frame evaluation against last-frame state.
  logic right_held;
  logic middle_held;
  logic left_held;
  logic pot_active;

  fid_run u_run_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .level_i    (right_q),
    .threshold_i(threshold_q),
    .held_o     (right_held)
  );

  fid_run u_run_middle (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .level_i    (middle_q),
    .threshold_i(threshold_q),
    .held_o     (middle_held)
  );

  fid_run u_run_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .level_i    (left_q),
    .threshold_i(threshold_q),
    .held_o     (left_held)
  );

  logic signed [fid_pkg::EncoderBits-1:0] last_pos_q;
  logic [2:0]                             last_held_q;
  logic                                   last_sw_q;
  logic                                   last_combo_q;
  logic [fid_pkg::PotBits-1:0]            last_pot_q;
  logic signed [fid_pkg::DeltaBits-1:0]   last_delta_q;

  fid_pot u_pot (
    .pot_i     (pot_q),
    .last_pot_i(last_pot_q),
    .scale_i   (scale_q),
    .sens_i    (sens_q),
    .active_o  (pot_active)
  );

  logic [2:0]                           held_d;
  logic                                 combo_d;
  logic signed [fid_pkg::DeltaBits-1:0] delta_d;
  logic                                 activity_d;
  logic [2:0]                           fell_d;

  // Bit 0 right, bit 1 middle, bit 2 left.
  assign held_d     = {left_held, middle_held, right_held};
  assign combo_d    = left_q & right_q;
  assign delta_d    = fid_pkg::DeltaBits'(last_pos_q) - fid_pkg::DeltaBits'(pos_q);
  assign fell_d     = last_held_q & ~held_d;
  assign activity_d = (delta_d != last_delta_q) || pot_active ||
                      (held_d != last_held_q) || (sw_q != last_sw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q   <= '0;
      last_held_q  <= '0;
      last_sw_q    <= 1'b0;
      last_combo_q <= 1'b0;
      last_pot_q   <= '0;
      last_delta_q <= '0;
    end else if (advance) begin
      last_pos_q   <= pos_q;
      last_held_q  <= held_d;
      last_sw_q    <= sw_q;
      last_combo_q <= combo_d;
      last_pot_q   <= pot_q;
      last_delta_q <= delta_d;
    end
  end

  // Result register stage.
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      right_held_o    <= held_d[0];
      middle_held_o   <= held_d[1];
      left_held_o     <= held_d[2];
      reset_combo_o   <= combo_d;
      pos_delta_o     <= delta_d;
      activity_o      <= activity_d;
      right_event_o   <= fell_d[0];
      middle_event_o  <= fell_d[1];
      left_event_o    <= fell_d[2];
      switch_event_o  <= last_sw_q & ~sw_q;
      reset_event_o   <= last_combo_q & ~combo_d;
      pot_changed_o   <= (pot_q != last_pot_q);
    end
  end

endmodule

>>> design/fid_run.sv
// Saturating run counter and held flag for one button.
`timescale 1ns / 1ps
module fid_run (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic                        level_i,
  input  logic [fid_pkg::ThreshW-1:0] threshold_i,
  output logic                        held_o
);

  logic [fid_pkg::RunBits-1:0] run_q;
  logic [fid_pkg::RunBits-1:0] run_d;

  always_comb begin
    if (!level_i) begin
      run_d = '0;
    end else if (run_q == fid_pkg::RUN_MAX) begin
      run_d = fid_pkg::RUN_MAX;
    end else begin
      run_d = run_q + 1'b1;
    end
  end

  // The held flag reflects the count after this frame's sample.
  assign held_o = (run_d > threshold_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (advance_i) begin
      run_q <= run_d;
    end
  end

endmodule

>>> design/fid_pot.sv
// Pot change detection against the scaled sensitivity threshold.
`timescale 1ns / 1ps
module fid_pot (
  input  logic [fid_pkg::PotBits-1:0] pot_i,
  input  logic [fid_pkg::PotBits-1:0] last_pot_i,
  input  logic [fid_pkg::ScaleW-1:0]  scale_i,
  input  logic [fid_pkg::SensW-1:0]   sens_i,
  output logic                        active_o
);

  logic [fid_pkg::PotBits-1:0] diff;
  logic [fid_pkg::ProdW-1:0]   prod;
  logic [fid_pkg::CmpW-1:0]    lhs;
  logic [fid_pkg::CmpW-1:0]    rhs;

  assign diff = (pot_i > last_pot_i) ? (pot_i - last_pot_i) : (last_pot_i - pot_i);
  assign prod = fid_pkg::ProdW'(diff) * fid_pkg::ProdW'(scale_i);

  // diff * scale * 256 > sens * 1024 reduces to diff * scale > sens * 4.
  assign lhs = fid_pkg::CmpW'(prod);
  assign rhs = fid_pkg::CmpW'({sens_i, 2'b00});
  assign active_o = (lhs > rhs);

endmodule
